// ----- hdl/ipq_pkg.sv -----
// Package for the interrupt priority task queue.
// Holds the beat types, the task and status codes, the controller states and
// the command bundle from controller to datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipq_pkg;

  // Configuration register indexes.
  localparam logic REG_UART_PRIO  = 1'b0;
  localparam logic REG_TIMER_PRIO = 1'b1;

  localparam logic [7:0] UART_PRIO_RESET  = 8'd1;
  localparam logic [7:0] TIMER_PRIO_RESET = 8'd0;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RX    = 2'd1,
    KIND_TX    = 2'd2,
    KIND_TIMER = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_UNKNOWN  = 3'd1,
    STAT_NO_CAUSE = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic func;
    logic aux_pending;
    logic rx_ready;
    logic tx_empty;
    logic timer_pending;
  } in_beat_t;

  typedef struct packed {
    kind_e      task_kind;
    status_e    status;
    logic [3:0] occupancy;
  } out_beat_t;

  // One queue entry: priority above, task kind below.
  typedef struct packed {
    logic [7:0] prio;
    kind_e      kind;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted input beat
    logic exec;  // carry out the captured item and load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ipq_ctrl.sv -----
// Controller of the interrupt priority task queue.
// Two-state sequencer plus the output valid flag; uses ipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipq_ctrl
  import ipq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    // A pending result leaves when the consumer takes it.
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // Wait here only while the previous result is still unclaimed.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/ipq_dpath.sv -----
// Datapath of the interrupt priority task queue: input capture, source
// decode, the sorted entry row with its count, and the result register.
// Uses ipq_pkg; driven by ipq_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module ipq_dpath
  import ipq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  input  wire in_beat_t   in_data_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  output out_beat_t       out_data_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  in_beat_t   item_q;
  logic [7:0] uart_prio_q, timer_prio_q;
  logic [CW-1:0] count_q, count_d;
  entry_t     ent_q   [QUEUE_DEPTH];
  entry_t     ent_d   [QUEUE_DEPTH];
  entry_t     ent_up  [QUEUE_DEPTH];
  entry_t     ent_dn  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep_b, keep_prev;
  out_beat_t  out_q, out_d;

  kind_e      ev_kind;
  logic [7:0] ev_prio;
  logic       ev_found;
  status_e    ev_status;
  entry_t     new_ent;
  logic       q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uart_prio_q  <= UART_PRIO_RESET;
      timer_prio_q <= TIMER_PRIO_RESET;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_UART_PRIO) begin
          uart_prio_q <= cfg_wdata_i;
        end else begin
          timer_prio_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ent_q[i] <= ent_d[i];
      end
    end
  end

  // Source decode: UART before the timer, receive before transmit.
  always_comb begin
    ev_kind   = KIND_NONE;
    ev_prio   = uart_prio_q;
    ev_found  = 1'b0;
    ev_status = STAT_DONE;
    if (item_q.aux_pending) begin
      if (item_q.rx_ready) begin
        ev_kind  = KIND_RX;
        ev_found = 1'b1;
      end else if (item_q.tx_empty) begin
        ev_kind  = KIND_TX;
        ev_found = 1'b1;
      end else begin
        ev_status = STAT_NO_CAUSE;
      end
    end else if (item_q.timer_pending) begin
      ev_kind  = KIND_TIMER;
      ev_prio  = timer_prio_q;
      ev_found = 1'b1;
    end else begin
      ev_status = STAT_UNKNOWN;
    end
  end

  assign new_ent = '{prio: ev_prio, kind: ev_kind};
  assign q_full  = (count_q == CW'(QUEUE_DEPTH));
  assign q_empty = (count_q == '0);

  // Each cell compares itself with the new entry. Cells that hold a priority
  // no larger than the new one form a prefix and stay; the first cell after
  // that prefix takes the new entry, the rest take their lower neighbor.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep_b[i] = (CW'(i) < count_q) && (ent_q[i].prio <= ev_prio);
    end
    keep_prev = {keep_b[QUEUE_DEPTH-2:0], 1'b1};
    ent_up[0] = new_ent;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      ent_up[i] = ent_q[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      ent_dn[i] = ent_q[i+1];
    end
    ent_dn[QUEUE_DEPTH-1] = ent_q[QUEUE_DEPTH-1];
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
    end
    out_d.task_kind = KIND_NONE;
    out_d.status    = STAT_DONE;
    if (item_q.func) begin
      if (q_empty) begin
        out_d.status = STAT_EMPTY;
      end else begin
        out_d.task_kind = ent_q[0].kind;
        count_d         = count_q - CW'(1);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          ent_d[i] = ent_dn[i];
        end
      end
    end else if (!ev_found) begin
      out_d.status = ev_status;
    end else begin
      out_d.task_kind = ev_kind;
      if (q_full) begin
        out_d.status = STAT_FULL;
      end else begin
        count_d = count_q + CW'(1);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (keep_b[i]) begin
            ent_d[i] = ent_q[i];
          end else if (keep_prev[i]) begin
            ent_d[i] = new_ent;
          end else begin
            ent_d[i] = ent_up[i];
          end
        end
      end
    end
    out_d.occupancy = 4'(count_d);
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- hdl/irq_priority_task_queue.sv -----
// Interrupt dispatcher with a stable sorted priority task queue.
// A result is loaded into the output register by the execute step that follows
// the capture of its input beat; that step waits while an older result still
// sits there unclaimed. The controller captures a beat while idle and runs the
// single parallel compare-and-shift over the entry row when executing, taking no
// new beat meanwhile. Reset clears the queue count and the output valid
// flag and restores the priorities (UART 1, timer 0); entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module irq_priority_task_queue
  import ipq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input channel: an event beat with pending flags, or a take request.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_beat_t   in_data_i,
  // Output channel: one result beat per input beat.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_beat_t       out_data_o,
  // Configuration write port: index 0 is the UART priority, 1 the timer one.
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  // The controller accepts a beat only in its idle state and then issues one
  // execute command. Execution waits while an older result still sits in the
  // output register unclaimed, so a new beat can be accepted while the
  // previous result is pending, and no result is ever overwritten.
  dp_cmd_t cmd;

  ipq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath keeps the entries sorted by priority, smallest first, with
  // new entries placed behind all of equal priority so that equal priorities
  // are served in arrival order. A full queue drops the new task and reports
  // it; a take from an empty queue reports that instead.
  ipq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
